### hdl/kht_pkg.sv
// Package: shared constants and types for the u64 key hash table.
`default_nettype none
package kht_pkg;
    localparam int unsigned SLOTS_DEF = 1024;
    localparam logic [63:0] HASH_M1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_M2 = 64'h94d049bb133111eb;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic KIND_PUT = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] key;
        logic [31:0] value;
        logic [31:0] hash;
    } t_cmd;

    // 64x64 product mod 2^64 from three 32x32 partial products (high x high drops out)
    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
    } t_part;
endpackage
`default_nettype wire

### hdl/kht_front.sv
// Front: accepts commands, computes the splitmix64 hash in pipeline stages.
`default_nettype none
module kht_front
    import kht_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic        i_kind,
    input  wire logic [63:0] i_key,
    input  wire logic [31:0] i_value,
    output logic             o_vld,
    output t_cmd             o_cmd
);
    localparam int NSTG = 5;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] r_kind;
    logic [63:0]     r_key   [NSTG];
    logic [31:0]     r_value [NSTG];
    logic [63:0]     r_x1, r_x3, r_x5;
    t_part           r_p1, r_p2;
    logic [63:0]     x0, x2, x4;

    assign x0 = i_key ^ (i_key >> 30);
    assign x2 = r_x1 ^ (r_x1 >> 27);
    assign x4 = r_x3 ^ (r_x3 >> 31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
        r_kind <= {r_kind[NSTG-2:0], i_kind};
        r_key[0] <= i_key;
        r_value[0] <= i_value;
        for (int s = 1; s < NSTG; s++) begin
            r_key[s] <= r_key[s-1];
            r_value[s] <= r_value[s-1];
        end
        r_p1.ll <= 64'(x0[31:0]) * 64'(HASH_M1[31:0]);
        r_p1.lh <= 64'(x0[31:0]) * 64'(HASH_M1[63:32]);
        r_p1.hl <= 64'(x0[63:32]) * 64'(HASH_M1[31:0]);
        r_x1 <= r_p1.ll + {r_p1.lh[31:0] + r_p1.hl[31:0], 32'd0};
        r_p2.ll <= 64'(x2[31:0]) * 64'(HASH_M2[31:0]);
        r_p2.lh <= 64'(x2[31:0]) * 64'(HASH_M2[63:32]);
        r_p2.hl <= 64'(x2[63:32]) * 64'(HASH_M2[31:0]);
        r_x3 <= r_p2.ll + {r_p2.lh[31:0] + r_p2.hl[31:0], 32'd0};
        r_x5 <= x4;
    end

    assign o_vld = r_vld[NSTG-1];
    assign o_cmd = '{kind: r_kind[NSTG-1], key: r_key[NSTG-1],
                     value: r_value[NSTG-1], hash: r_x5[31:0]};
endmodule
`default_nettype wire

### hdl/kht_fifo.sv
// Small command queue between front and back.
`default_nettype none
module kht_fifo
    import kht_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_data,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_data
);
    localparam int AW = $clog2(DEPTH);
    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
endmodule
`default_nettype wire

### hdl/kht_back.sv
// Back: probes the slot memory and performs put or get.
`default_nettype none
module kht_back
    import kht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_idle,
    output logic             o_strobe,
    output logic [2:0]       o_status,
    output logic [31:0]      o_value_out
);
    localparam int AW = $clog2(SLOTS);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_CHECK, S_CLEAR} t_state;

    t_state         r_state;
    logic           r_vmark [SLOTS];
    logic [63:0]    r_kmem [SLOTS];
    logic [31:0]    r_vmem [SLOTS];
    logic [63:0]    r_rkey;
    logic [31:0]    r_rval;
    logic           r_rvalid;
    t_cmd           r_cmd;
    logic [AW-1:0]  r_slot, r_step;
    logic [AW-1:0]  r_clr;
    logic [AW:0]    r_i;
    logic [AW:0]    r_count;
    logic           r_strobe;
    logic [2:0]     r_status;
    logic [31:0]    r_vout;
    logic           wr_en;
    logic [AW-1:0]  n_slot;
    logic           full;
    logic           clearing;
    logic           mark_we;
    logic [AW-1:0]  mark_addr;

    // slot(i+1) = slot(i) + (i+1)
    assign n_slot = r_slot + r_step;
    assign full   = ((32'(r_count) + 32'd1) * 32'd2) >= 32'(SLOTS);
    assign wr_en  = (r_state == S_CHECK) && (r_cmd.kind == KIND_PUT) &&
                    ((r_rvalid && r_rkey == r_cmd.key) || (!r_rvalid && !full));
    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign o_idle = (r_state == S_IDLE) && i_empty;

    // valid marks: cleared one slot per cycle after reset, set on insert
    assign clearing  = (r_state == S_CLEAR);
    assign mark_we   = clearing || (wr_en && !r_rvalid);
    assign mark_addr = clearing ? r_clr : r_slot;

    always_ff @(posedge i_clk) begin
        r_rkey   <= r_kmem[r_slot];
        r_rval   <= r_vmem[r_slot];
        r_rvalid <= r_vmark[r_slot];
        if (wr_en) begin
            r_kmem[r_slot] <= r_cmd.key;
            r_vmem[r_slot] <= r_cmd.value;
        end
        if (mark_we) r_vmark[mark_addr] <= !clearing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_slot  <= i_cmd.hash[AW-1:0];
                        r_step  <= AW'(1);
                        r_i     <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_vout <= '0;
                    if (!r_rvalid) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                        if (r_cmd.kind == KIND_PUT) begin
                            if (full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_INSERTED;
                                r_count <= r_count + 1'b1;
                            end
                        end else begin
                            r_status <= ST_NOT_FOUND;
                        end
                    end else if (r_rkey == r_cmd.key) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                        if (r_cmd.kind == KIND_PUT) begin
                            r_status <= ST_UPDATED;
                        end else begin
                            r_status <= ST_FOUND;
                            r_vout   <= r_rval;
                        end
                    end else if (r_i == (AW+1)'(SLOTS - 1)) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                        r_status <= (r_cmd.kind == KIND_PUT) ? ST_FULL : ST_NOT_FOUND;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_slot  <= n_slot;
                        r_step  <= r_step + 1'b1;
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
endmodule
`default_nettype wire

### hdl/u64_key_hash_table_unit.sv
// Top level: u64-keyed open-addressing hash table with triangular probing.
// An accepted beat passes the 5 hash stages, a queue write and a pop, then reads and checks
// slot after slot; the back end finishes one item before it pops the next from the queue.
// The probe loop over the single-port slot memory sets the rate; the queue holds 8 items.
// Synchronous active-low reset clears count, queue and pipeline, then a pass over all slots
// clears the valid marks; beats taken meanwhile wait in the queue. o_done cannot be stalled.
`default_nettype none
module u64_key_hash_table_unit
    import kht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_kind,
    input  wire logic [63:0] i_key,
    input  wire logic [31:0] i_value,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [31:0]      o_value_out
);
    localparam int QD = 8;
    logic acc, f_vld, q_empty, q_pop, b_idle;
    t_cmd f_cmd, q_cmd;
    logic [3:0] r_inflight;

    assign acc = start && !busy;
    // queue slots reserved for items in the hash pipeline
    assign busy = (r_inflight >= 4'(QD - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 4'(acc) - 4'(q_pop);
        end
    end

    kht_front u_front (
        .i_clk, .i_rst_n, .i_vld(acc), .i_kind, .i_key, .i_value,
        .o_vld(f_vld), .o_cmd(f_cmd)
    );

    kht_fifo #(.DEPTH(QD)) u_fifo (
        .i_clk, .i_rst_n, .i_push(f_vld), .i_data(f_cmd),
        .i_pop(q_pop), .o_empty(q_empty), .o_data(q_cmd)
    );

    kht_back #(.SLOTS(SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_cmd(q_cmd), .o_pop(q_pop),
        .o_idle(b_idle), .o_strobe(o_done), .o_status, .o_value_out
    );

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 4'(QD)) else $error("inflight overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("pop from empty queue");
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= ST_FULL)) else $error("bad status");
    a_idle_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_idle && r_inflight == '0) |=> !o_done) else $error("spurious result");
endmodule
`default_nettype wire

### test/kht_checker.sv
// Checker: predicts hash table results from accepted beats and compares them.
`timescale 1ns / 100ps
module kht_checker
    import kht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic        i_kind,
    input  wire logic [63:0] i_key,
    input  wire logic [31:0] i_value,
    input  wire logic        i_done,
    input  wire logic [2:0]  i_status,
    input  wire logic [31:0] i_value_out,
    output int               o_err_cnt,
    output int               o_pending,
    output int               o_keys,
    output int               o_refused
);
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
    } t_answer;

    logic        tbl_valid [SLOTS];
    logic [63:0] tbl_key   [SLOTS];
    logic [31:0] tbl_value [SLOTS];
    int unsigned tbl_count;
    t_answer     answers_due[$];

    function automatic logic [31:0] mix_key(input logic [63:0] k);
        logic [63:0] x;
        x = k;
        x = x ^ (x >> 30);
        x = x * HASH_M1;
        x = x ^ (x >> 27);
        x = x * HASH_M2;
        x = x ^ (x >> 31);
        return x[31:0];
    endfunction

    // Walks the probe chain for a put or get and applies a put to the shadow table.
    function automatic t_answer table_access(input logic kind, input logic [63:0] k,
                                             input logic [31:0] v);
        t_answer     ans;
        logic [31:0] h;
        logic [31:0] tri_off;
        int unsigned s;
        h = mix_key(k);
        ans.status = (kind == KIND_PUT) ? ST_FULL : ST_NOT_FOUND;
        ans.value_out = '0;
        for (int unsigned i = 0; i < SLOTS; i++) begin
            tri_off = (i * (i + 1)) / 2;
            s = (h + tri_off) & (SLOTS - 1);
            if (!tbl_valid[s]) begin
                if (kind == KIND_PUT) begin
                    if ((tbl_count + 1) * 2 >= SLOTS) begin
                        ans.status = ST_FULL;
                    end else begin
                        tbl_valid[s] = 1'b1;
                        tbl_key[s] = k;
                        tbl_value[s] = v;
                        tbl_count++;
                        ans.status = ST_INSERTED;
                    end
                end else begin
                    ans.status = ST_NOT_FOUND;
                end
                break;
            end
            if (tbl_key[s] == k) begin
                if (kind == KIND_PUT) begin
                    tbl_value[s] = v;
                    ans.status = ST_UPDATED;
                end else begin
                    ans.value_out = tbl_value[s];
                    ans.status = ST_FOUND;
                end
                break;
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
            tbl_count = 0;
            answers_due.delete();
            o_err_cnt <= 0;
            o_refused <= 0;
        end else begin
            if (i_done) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with nothing expected: status %0d", i_status);
                    o_err_cnt <= o_err_cnt + 1;
                end else begin
                    exp_ans = answers_due.pop_front();
                    if (i_status !== exp_ans.status) begin
                        $error("status: expected %0d, got %0d", exp_ans.status, i_status);
                        o_err_cnt <= o_err_cnt + 1;
                    end else if (i_value_out !== exp_ans.value_out) begin
                        $error("value_out: expected %0d, got %0d",
                               $signed(exp_ans.value_out), $signed(i_value_out));
                        o_err_cnt <= o_err_cnt + 1;
                    end
                    if (exp_ans.status == ST_FULL) o_refused <= o_refused + 1;
                end
            end
            if (i_start && !i_busy) answers_due.push_back(table_access(i_kind, i_key, i_value));
        end
        o_pending <= answers_due.size();
        o_keys <= tbl_count;
    end
endmodule

### test/tb_u64_key_hash_table_unit.sv
// Testbench top: drives put/get beats into the hash table and gives the verdict.
`timescale 1ns / 100ps
module tb_u64_key_hash_table_unit;
    import kht_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = KIND_PUT;
    logic [63:0] i_key = '0;
    logic [31:0] i_value = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [31:0] o_value_out;
    int          err_cnt, pending, keys_held, refused;
    int          idle_cycles = 0;
    int          n_put = 0, n_get = 0;
    logic [63:0] known_keys[$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    u64_key_hash_table_unit i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_kind, .i_key, .i_value,
        .o_done, .o_status, .o_value_out
    );

    kht_checker u_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_kind, .i_key, .i_value,
        .i_done(o_done), .i_status(o_status), .i_value_out(o_value_out),
        .o_err_cnt(err_cnt), .o_pending(pending), .o_keys(keys_held), .o_refused(refused)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_beat(input logic kind, input logic [63:0] k, input logic [31:0] v,
                             input int gap);
        @(negedge i_clk);
        start = 1'b1;
        i_kind = kind;
        i_key = k;
        i_value = v;
        do @(posedge i_clk); while (busy);
        if (kind == KIND_PUT) begin
            n_put++;
            known_keys.push_back(k);
        end else begin
            n_get++;
        end
        for (int g = 0; g < gap; g++) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key(input int new_pct);
        if (known_keys.size() == 0 || $urandom_range(99) < new_pct) return rand_key();
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    task automatic random_phase(input int n, input int put_pct, input int new_pct,
                                input int max_gap);
        logic kind;
        for (int j = 0; j < n; j++) begin
            kind = ($urandom_range(99) < put_pct) ? KIND_PUT : KIND_GET;
            send_beat(kind, pick_key(kind == KIND_PUT ? new_pct : 30), $urandom(),
                      $urandom_range(max_gap));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(KIND_GET, 64'd0, 32'd0, 0);
        send_beat(KIND_PUT, 64'd0, 32'h7fffffff, 0);
        send_beat(KIND_PUT, '1, 32'h80000000, 1);
        send_beat(KIND_GET, 64'd0, '1, 0);
        send_beat(KIND_GET, '1, 32'd0, 3);
        send_beat(KIND_PUT, 64'd0, '1, 0);
        send_beat(KIND_GET, 64'd0, 32'd0, 0);
        send_beat(KIND_PUT, 64'h8000000000000000, 32'd0, 2);
        send_beat(KIND_PUT, 64'd1, 32'd1, 0);
        send_beat(KIND_GET, 64'h8000000000000000, 32'h55555555, 0);
        send_beat(KIND_GET, 64'd1, 32'd0, 18);
        send_beat(KIND_GET, 64'd2, 32'd0, 0);
        send_beat(KIND_GET, 64'h7fffffffffffffff, 32'd0, 0);
        send_beat(KIND_PUT, '1, 32'd0, 0);
        send_beat(KIND_GET, '1, 32'd0, 0);
        send_beat(KIND_PUT, 64'haaaaaaaaaaaaaaaa, 32'haaaaaaaa, 5);
        send_beat(KIND_GET, 64'haaaaaaaaaaaaaaaa, 32'd0, 0);
        send_beat(KIND_GET, 64'h5555555555555555, 32'd0, 0);

        random_phase(150, 85, 85, 0);
        random_phase(400, 85, 80, 18);
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        random_phase(300, 65, 60, 18);
        random_phase(250, 50, 40, 4);

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d puts and %0d gets; %0d keys stored, %0d puts refused as full",
                 n_put, n_get, keys_held, refused);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

### u64_key_hash_table_unit.f
hdl/kht_pkg.sv
hdl/kht_front.sv
hdl/kht_fifo.sv
hdl/kht_back.sv
hdl/u64_key_hash_table_unit.sv
test/kht_checker.sv
test/tb_u64_key_hash_table_unit.sv
